/* sv/kea_pkg.sv */
package kea_pkg;

  localparam int unsigned KeyW  = 8;
  localparam int unsigned CodeW = 2;
  localparam int unsigned AddrW = 3;
  localparam int unsigned DataW = 32;

  localparam logic [CodeW-1:0] EV_NONE     = 2'd0;
  localparam logic [CodeW-1:0] EV_PRESSED  = 2'd1;
  localparam logic [CodeW-1:0] EV_RELEASED = 2'd2;

  localparam logic REQ_POLL = 1'b0;
  localparam logic REQ_GET  = 1'b1;

  localparam logic REG_KEY_MASK     = 1'b0;
  localparam logic REG_REPEAT_LIMIT = 1'b1;

  localparam logic [KeyW-1:0] MASK_RESET  = 8'hEC;
  localparam logic [KeyW-1:0] LIMIT_RESET = 8'd5;

  typedef struct packed {
    logic [KeyW-1:0]  key_status;
    logic [KeyW-1:0]  tick_count;
    logic [CodeW-1:0] pending_code;
    logic [KeyW-1:0]  pending_key;
  } kea_poll_t;

endpackage

/* sv/kea_if.sv */
interface kea_req_if;
  import kea_pkg::*;
  logic            valid;
  logic            ready;
  logic            req_type;
  logic [KeyW-1:0] pin_sample;

  modport source (output valid, output req_type, output pin_sample, input ready);
  modport sink   (input valid, input req_type, input pin_sample, output ready);
endinterface

interface kea_rsp_if;
  import kea_pkg::*;
  logic             valid;
  logic             ready;
  logic [CodeW-1:0] event_code;
  logic [KeyW-1:0]  event_key;

  modport source (output valid, output event_code, output event_key, input ready);
  modport sink   (input valid, input event_code, input event_key, output ready);
endinterface

/* sv/kea_scan.sv */
module kea_scan
  import kea_pkg::*;
(
  input  logic [KeyW-1:0]  pin_sample,
  input  logic [KeyW-1:0]  key_enable_mask,
  input  logic [KeyW-1:0]  repeat_limit,
  input  logic [KeyW-1:0]  key_status,
  input  logic [KeyW-1:0]  tick_count,
  input  logic [CodeW-1:0] pending_code,
  input  logic [KeyW-1:0]  pending_key,
  input  logic [CodeW-1:0] last_taken_code,
  input  logic [KeyW-1:0]  last_taken_key,
  output kea_poll_t        poll
);

  logic [KeyW-1:0] masked;
  logic [KeyW-1:0] diff;
  logic [KeyW-1:0] tick_inc;
  logic [KeyW-1:0] top_key;
  logic            top_up;

  assign masked   = pin_sample & key_enable_mask;
  assign diff     = key_enable_mask & (pin_sample ^ key_status);
  assign tick_inc = tick_count + 8'd1;

  // pick the highest changed enabled key
  always_comb begin
    top_key = '0;
    top_up  = 1'b0;
    for (int b = 0; b < KeyW; b++) begin
      if (diff[b]) begin
        top_key    = '0;
        top_key[b] = 1'b1;
        top_up     = pin_sample[b];
      end
    end
  end

  always_comb begin
    poll.key_status   = key_status;
    poll.tick_count   = tick_inc;
    poll.pending_code = pending_code;
    poll.pending_key  = pending_key;
    if (masked != key_status) begin
      poll.tick_count = '0;
      poll.key_status = masked;
      if (diff != '0) begin
        poll.pending_code = top_up ? EV_RELEASED : EV_PRESSED;
        poll.pending_key  = top_key;
      end
    end else if (tick_inc > repeat_limit) begin
      poll.tick_count   = '0;
      poll.pending_code = last_taken_code;
      poll.pending_key  = last_taken_key;
    end
  end

endmodule

/* sv/key_edge_event_autorepeat.sv */
// A get item's event is registered in the output register, or in the skid when
// that is full. One item per cycle while the skid is empty; a two-entry output
// buffer (register plus skid) lets req keep flowing while a result waits on rsp.
// Reset (rst, synchronous): mask 0xEC, repeat limit 5, all keys released,
// tick count zero, pending and last-taken events none, output buffer empty.
module key_edge_event_autorepeat
  import kea_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  kea_req_if.sink          req,
  kea_rsp_if.source        rsp,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready
);

  logic [KeyW-1:0]  key_enable_mask;
  logic [KeyW-1:0]  repeat_limit;
  logic [KeyW-1:0]  key_status;
  logic [KeyW-1:0]  tick_count;
  logic [CodeW-1:0] pending_code;
  logic [KeyW-1:0]  pending_key;
  logic [CodeW-1:0] last_taken_code;
  logic [KeyW-1:0]  last_taken_key;

  logic             obuf_valid;
  logic [CodeW-1:0] obuf_code;
  logic [KeyW-1:0]  obuf_key;
  logic             skid_valid;
  logic [CodeW-1:0] skid_code;
  logic [KeyW-1:0]  skid_key;

  logic      accept;
  logic      push;
  logic      pop;
  logic      cfg_wr;
  kea_poll_t poll;

  assign pready    = 1'b1;
  assign cfg_wr    = psel && penable && pwrite;
  assign prdata    = {{(DataW-KeyW){1'b0}},
                      (paddr[2] == REG_REPEAT_LIMIT) ? repeat_limit : key_enable_mask};

  assign req.ready = !skid_valid;
  assign accept    = req.valid && req.ready;
  assign push      = accept && (req.req_type == REQ_GET);
  assign pop       = rsp.valid && rsp.ready;

  assign rsp.valid      = obuf_valid;
  assign rsp.event_code = obuf_code;
  assign rsp.event_key  = obuf_key;

  kea_scan u_scan (
    .pin_sample      (req.pin_sample),
    .key_enable_mask (key_enable_mask),
    .repeat_limit    (repeat_limit),
    .key_status      (key_status),
    .tick_count      (tick_count),
    .pending_code    (pending_code),
    .pending_key     (pending_key),
    .last_taken_code (last_taken_code),
    .last_taken_key  (last_taken_key),
    .poll            (poll)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      key_enable_mask <= MASK_RESET;
      repeat_limit    <= LIMIT_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_REPEAT_LIMIT) begin
        repeat_limit <= pwdata[KeyW-1:0];
      end else begin
        key_enable_mask <= pwdata[KeyW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_status      <= MASK_RESET;
      tick_count      <= '0;
      pending_code    <= EV_NONE;
      pending_key     <= '0;
      last_taken_code <= EV_NONE;
      last_taken_key  <= '0;
    end else if (accept) begin
      if (req.req_type == REQ_POLL) begin
        key_status   <= poll.key_status;
        tick_count   <= poll.tick_count;
        pending_code <= poll.pending_code;
        pending_key  <= poll.pending_key;
      end else if (pending_code != EV_NONE) begin
        last_taken_code <= pending_code;
        last_taken_key  <= pending_key;
        pending_code    <= EV_NONE;
        pending_key     <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      obuf_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        obuf_code  <= skid_code;
        obuf_key   <= skid_key;
        skid_valid <= 1'b0;
      end else begin
        obuf_valid <= push;
        obuf_code  <= pending_code;
        obuf_key   <= pending_key;
      end
    end else if (push) begin
      if (!obuf_valid) begin
        obuf_valid <= 1'b1;
        obuf_code  <= pending_code;
        obuf_key   <= pending_key;
      end else begin
        skid_valid <= 1'b1;
        skid_code  <= pending_code;
        skid_key   <= pending_key;
      end
    end
  end

  a_skid_behind_obuf: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> obuf_valid)
    else $error("skid entry held with empty output register");

  a_pending_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0(pending_key) && ((pending_code == EV_NONE) == (pending_key == '0)))
    else $error("pending event code and key disagree");

  a_get_shows: assert property (@(posedge clk) disable iff (rst)
    (push && !obuf_valid) |=> obuf_valid)
    else $error("get item produced no result");

  a_change_clears_tick: assert property (@(posedge clk) disable iff (rst)
    (accept && req.req_type == REQ_POLL &&
     (req.pin_sample & key_enable_mask) != key_status) |=> tick_count == '0)
    else $error("pin change did not clear tick count");

endmodule

/* test/tb_top.sv */
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import kea_pkg::*;

  typedef struct packed {
    logic [CodeW-1:0] code;
    logic [KeyW-1:0]  key;
  } key_event_t;

  typedef struct packed {
    logic             rt;
    logic [KeyW-1:0]  pins;
    logic             typed;
    logic [CodeW-1:0] code;
    logic [KeyW-1:0]  key;
  } dir_row_t;

  logic             clk;
  logic             rst;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [AddrW-1:0] paddr;
  logic [DataW-1:0] pwdata;
  logic [DataW-1:0] prdata;
  logic             pready;

  kea_req_if req_bus();
  kea_rsp_if rsp_bus();

  key_edge_event_autorepeat DUT (
    .clk     (clk),
    .rst     (rst),
    .req     (req_bus),
    .rsp     (rsp_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  logic [KeyW-1:0] cfg_mask;
  logic [KeyW-1:0] cfg_limit;
  logic [KeyW-1:0] key_state;
  logic [KeyW-1:0] tick_cnt;
  key_event_t      pend_ev;
  key_event_t      taken_ev;
  logic [KeyW-1:0] last_pins;
  logic            hold_done;

  key_event_t events_due[$];
  dir_row_t   dir_rows[25];

  int idle_pct;
  int stall_pct;
  int hold_cycles;
  int n_items;
  int n_events;
  int n_cfg;
  int n_bad;

  initial clk = 1'b0;
  always #2 clk = ~clk;

  initial begin
    #400000;
    $display("[key_edge_event_autorepeat] ERROR");
    $finish;
  end

  function automatic void apply_poll(input logic [KeyW-1:0] pins);
    logic [KeyW-1:0] masked;
    logic [KeyW-1:0] onehot;
    masked = pins & cfg_mask;
    tick_cnt = tick_cnt + 1'b1;
    if (masked != key_state) begin
      tick_cnt = '0;
      for (int b = 0; b < KeyW; b++) begin
        onehot = '0;
        onehot[b] = 1'b1;
        if (cfg_mask[b] && pins[b] && !key_state[b]) begin
          pend_ev = '{EV_RELEASED, onehot};
        end
        if (cfg_mask[b] && !pins[b] && key_state[b]) begin
          pend_ev = '{EV_PRESSED, onehot};
        end
      end
      key_state = masked;
    end else if (tick_cnt > cfg_limit) begin
      tick_cnt = '0;
      pend_ev = taken_ev;
    end
  endfunction

  function automatic key_event_t apply_get();
    key_event_t cur;
    cur = pend_ev;
    if (cur.code != EV_NONE) begin
      taken_ev = cur;
      pend_ev = '0;
    end
    return cur;
  endfunction

  task automatic send_item(input logic rt, input logic [KeyW-1:0] pins, input logic typed,
                           input key_event_t typed_ev);
    key_event_t got;
    if ($urandom_range(99) < idle_pct) begin
      req_bus.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    req_bus.valid      <= 1'b1;
    req_bus.req_type   <= rt;
    req_bus.pin_sample <= pins;
    do @(posedge clk); while (!req_bus.ready);
    n_items++;
    if (rt == REQ_GET) begin
      got = apply_get();
      events_due.push_back(typed ? typed_ev : got);
    end else begin
      apply_poll(pins);
      last_pins = pins;
    end
  endtask

  task automatic wait_idle();
    req_bus.valid <= 1'b0;
    while (events_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic reg_write(input logic idx, input logic [KeyW-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {{(DataW-KeyW){1'b0}}, val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_KEY_MASK) cfg_mask = val;
    else cfg_limit = val;
  endtask

  task automatic run_phase(input logic [KeyW-1:0] mask, input logic [KeyW-1:0] lim,
                           input int idle, input int stall, input int steady,
                           input int count);
    int r;
    wait_idle();
    reg_write(REG_KEY_MASK, mask);
    reg_write(REG_REPEAT_LIMIT, lim);
    n_cfg++;
    idle_pct  = idle;
    stall_pct = stall;
    repeat (steady) send_item(REQ_POLL, last_pins, 1'b0, '0);
    repeat (count) begin
      r = $urandom_range(99);
      if (r < 30) send_item(REQ_GET, KeyW'($urandom), 1'b0, '0);
      else if (r < 72) send_item(REQ_POLL, last_pins, 1'b0, '0);
      else if (r < 90) begin
        send_item(REQ_POLL, last_pins ^ (8'h01 << $urandom_range(7)), 1'b0, '0);
      end else send_item(REQ_POLL, KeyW'($urandom), 1'b0, '0);
    end
  endtask

  initial begin
    rsp_bus.ready = 1'b0;
    hold_done     = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0 && !hold_done) begin
        rsp_bus.ready <= 1'b0;
        repeat (hold_cycles) @(posedge clk);
        hold_done = 1'b1;
      end
      rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    key_event_t want;
    if (!rst && rsp_bus.valid && rsp_bus.ready) begin
      if (events_due.size() == 0) begin
        $display("%0t: unexpected item code %0d key %h", $time, rsp_bus.event_code,
                 rsp_bus.event_key);
        n_bad++;
      end else begin
        want = events_due.pop_front();
        n_events++;
        if (rsp_bus.event_code !== want.code) begin
          $display("%0t: event_code expected %0d got %0d", $time, want.code,
                   rsp_bus.event_code);
          n_bad++;
        end
        if (rsp_bus.event_key !== want.key) begin
          $display("%0t: event_key expected %h got %h", $time, want.key, rsp_bus.event_key);
          n_bad++;
        end
      end
    end
  end

  initial begin
    rst                = 1'b1;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    req_bus.valid      = 1'b0;
    req_bus.req_type   = REQ_POLL;
    req_bus.pin_sample = '0;
    idle_pct           = 0;
    stall_pct          = 0;
    hold_cycles        = 0;
    n_items            = 0;
    n_events           = 0;
    n_cfg              = 1;
    n_bad              = 0;
    cfg_mask           = MASK_RESET;
    cfg_limit          = LIMIT_RESET;
    key_state          = MASK_RESET;
    tick_cnt           = '0;
    pend_ev            = '0;
    taken_ev           = '0;
    last_pins          = 8'hFF;

    dir_rows = '{
      '{REQ_GET,  8'h00, 1'b1, EV_NONE,     8'h00},
      '{REQ_POLL, 8'hFF, 1'b0, EV_NONE,     8'h00},
      '{REQ_POLL, 8'hFF, 1'b0, EV_NONE,     8'h00},
      '{REQ_POLL, 8'hFF, 1'b0, EV_NONE,     8'h00},
      '{REQ_POLL, 8'hFF, 1'b0, EV_NONE,     8'h00},
      '{REQ_POLL, 8'hFF, 1'b0, EV_NONE,     8'h00},
      '{REQ_POLL, 8'hFF, 1'b0, EV_NONE,     8'h00},
      '{REQ_GET,  8'hFF, 1'b1, EV_NONE,     8'h00},
      '{REQ_POLL, 8'hFB, 1'b0, EV_NONE,     8'h00},
      '{REQ_GET,  8'h00, 1'b1, EV_PRESSED,  8'h04},
      '{REQ_GET,  8'h00, 1'b1, EV_NONE,     8'h00},
      '{REQ_POLL, 8'h00, 1'b0, EV_NONE,     8'h00},
      '{REQ_POLL, 8'hFF, 1'b0, EV_NONE,     8'h00},
      '{REQ_GET,  8'h55, 1'b0, EV_NONE,     8'h00},
      '{REQ_POLL, 8'h13, 1'b0, EV_NONE,     8'h00},
      '{REQ_POLL, 8'h13, 1'b0, EV_NONE,     8'h00},
      '{REQ_POLL, 8'h13, 1'b0, EV_NONE,     8'h00},
      '{REQ_POLL, 8'h13, 1'b0, EV_NONE,     8'h00},
      '{REQ_POLL, 8'h13, 1'b0, EV_NONE,     8'h00},
      '{REQ_POLL, 8'h13, 1'b0, EV_NONE,     8'h00},
      '{REQ_POLL, 8'h13, 1'b0, EV_NONE,     8'h00},
      '{REQ_GET,  8'hAA, 1'b0, EV_NONE,     8'h00},
      '{REQ_POLL, 8'h01, 1'b0, EV_NONE,     8'h00},
      '{REQ_POLL, 8'hEC, 1'b0, EV_NONE,     8'h00},
      '{REQ_GET,  8'hFF, 1'b0, EV_NONE,     8'h00}
    };

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      send_item(dir_rows[i].rt, dir_rows[i].pins, dir_rows[i].typed,
                '{dir_rows[i].code, dir_rows[i].key});
    end

    run_phase(8'hFF, 8'd0,   0,  0,   0, 80);
    run_phase(8'h00, 8'd3,   49, 0,   0, 80);
    run_phase(8'h5A, 8'd255, 0,  49,  260, 40);
    run_phase(8'hA5, 8'd1,   30, 30,  0, 80);
    run_phase(KeyW'($urandom), KeyW'($urandom_range(8)), 49, 0, 0, 80);

    wait_idle();
    idle_pct    = 0;
    hold_cycles = 200;
    repeat (20) begin
      send_item(REQ_POLL, last_pins ^ (8'h01 << $urandom_range(7)), 1'b0, '0);
      send_item(REQ_GET, KeyW'($urandom), 1'b0, '0);
    end

    run_phase(8'h0F, 8'd2, 0, 49, 0, 80);

    wait_idle();
    repeat (8) @(posedge clk);

    $display("Sent %0d items, checked %0d events over %0d register settings,",
             n_items, n_events, n_cfg);
    $display("with sender gaps, receiver stalls and one long output hold-off.");
    if (n_bad == 0) begin
      $display("[key_edge_event_autorepeat] OK");
    end else begin
      $display("[key_edge_event_autorepeat] ERROR");
    end
    $finish;
  end

endmodule
